// File: rtl/wbva_pkg.sv
// Package for the weighted baseline visibility accumulator.
// Holds sizes, status, operation and register index codes, the command type and a shared function.
// No dependencies.
`default_nettype none
package wbva_pkg;
   localparam int MAX_ANTENNAS = 16;
   localparam int MAX_BEAMS    = 4;
   localparam int MAX_POLS     = 4;
   localparam int ROWS         = MAX_BEAMS * (MAX_ANTENNAS * (MAX_ANTENNAS - 1) / 2);
   localparam int DEPTH        = ROWS * MAX_POLS;
   localparam int ADDR_W       = $clog2(DEPTH);
   localparam int ROW_W        = $clog2(ROWS);

   localparam logic [1:0] OP_ACC   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] CSR_NUM_ANT   = 2'd0;
   localparam logic [1:0] CSR_NUM_BEAMS = 2'd1;
   localparam logic [1:0] CSR_NUM_POLS  = 2'd2;

   localparam logic [2:0] ST_ACC     = 3'd0;
   localparam logic [2:0] ST_TYPE    = 3'd1;
   localparam logic [2:0] ST_NOMATCH = 3'd2;
   localparam logic [2:0] ST_FLAG    = 3'd3;
   localparam logic [2:0] ST_READ    = 3'd4;
   localparam logic [2:0] ST_CLEAR   = 3'd5;

   typedef enum logic [2:0] {
      K_ACC, K_TYPE, K_NOMATCH, K_FLAG, K_RDHIT, K_RDMISS, K_CLEAR
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [ADDR_W-1:0]       idx;
      logic signed [15:0]      model_re;
      logic signed [15:0]      model_im;
      logic signed [15:0]      meas_re;
      logic signed [15:0]      meas_im;
      logic signed [15:0]      noise_re;
   } cmd_type;

   function automatic logic [6:0] tri_num(input logic [4:0] n);
      logic [9:0] p;
      p = {5'd0, n} * ({5'd0, n} - 10'd1);
      return p[7:1];
   endfunction
endpackage
`default_nettype wire

// File: rtl/wbva_ifs.sv
// Handshake channels of the accumulator: request and response items.
// No dependencies.
`default_nettype none
interface wbva_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic [3:0]         antenna_a;
   logic [3:0]         antenna_b;
   logic [1:0]         beam_a;
   logic [1:0]         beam_b;
   logic [1:0]         pol_index;
   logic               sample_flagged;
   logic signed [15:0] model_re;
   logic signed [15:0] model_im;
   logic signed [15:0] meas_re;
   logic signed [15:0] meas_im;
   logic signed [15:0] noise_re;
   modport source(output valid, operation, antenna_a, antenna_b, beam_a, beam_b, pol_index,
                  sample_flagged, model_re, model_im, meas_re, meas_im, noise_re,
                  input ready);
   modport sink(input valid, operation, antenna_a, antenna_b, beam_a, beam_b, pol_index,
                sample_flagged, model_re, model_im, meas_re, meas_im, noise_re,
                output ready);
endinterface

interface wbva_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [46:0]        amp_sum;
   logic signed [47:0] product_sum_re;
   logic signed [47:0] product_sum_im;
   logic               entry_flagged;
   logic [31:0]        type_ignored_count;
   logic [31:0]        no_match_count;
   logic [31:0]        flag_ignored_count;
   modport source(output valid, status, amp_sum, product_sum_re, product_sum_im,
                  entry_flagged, type_ignored_count, no_match_count, flag_ignored_count,
                  input ready);
   modport sink(input valid, status, amp_sum, product_sum_re, product_sum_im,
                entry_flagged, type_ignored_count, no_match_count, flag_ignored_count,
                output ready);
endinterface
`default_nettype wire

// File: rtl/wbva_front.sv
// Front end: configuration registers, item acceptance and classification.
// Depends on wbva_pkg and wbva_req_if.
`default_nettype none
module wbva_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [4:0]       csr_wdata,
   wbva_req_if.sink         req_ch,
   input  logic             hold_off,
   input  logic             q_full,
   output logic             push,
   output wbva_pkg::cmd_type cmd
);
   logic [4:0] num_antennas_ff;
   logic [2:0] num_beams_ff;
   logic [2:0] num_pols_ff;
   logic [4:0] na;
   logic [2:0] nb;
   logic [2:0] np;
   logic       loc;
   logic       pol_ok;
   logic [wbva_pkg::ROW_W-1:0] row;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_antennas_ff <= 5'(wbva_pkg::MAX_ANTENNAS);
         num_beams_ff    <= 3'(wbva_pkg::MAX_BEAMS);
         num_pols_ff     <= 3'(wbva_pkg::MAX_POLS);
      end else if (csr_wr_en) begin
         case (csr_index)
            wbva_pkg::CSR_NUM_ANT:   num_antennas_ff <= csr_wdata;
            wbva_pkg::CSR_NUM_BEAMS: num_beams_ff    <= csr_wdata[2:0];
            wbva_pkg::CSR_NUM_POLS:  num_pols_ff     <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      na = (num_antennas_ff > 5'(wbva_pkg::MAX_ANTENNAS)) ?
           5'(wbva_pkg::MAX_ANTENNAS) : num_antennas_ff;
      nb = (num_beams_ff > 3'(wbva_pkg::MAX_BEAMS)) ? 3'(wbva_pkg::MAX_BEAMS) : num_beams_ff;
      np = (num_pols_ff > 3'(wbva_pkg::MAX_POLS)) ? 3'(wbva_pkg::MAX_POLS) : num_pols_ff;
      loc = (req_ch.antenna_a > req_ch.antenna_b) && ({1'b0, req_ch.antenna_a} < na) &&
            ({1'b0, req_ch.beam_a} < nb);
      pol_ok = {1'b0, req_ch.pol_index} < np;
      row = wbva_pkg::ROW_W'(wbva_pkg::tri_num(na)) * wbva_pkg::ROW_W'(req_ch.beam_a)
          + wbva_pkg::ROW_W'(wbva_pkg::tri_num({1'b0, req_ch.antenna_a}))
          + wbva_pkg::ROW_W'(req_ch.antenna_b);
      cmd.idx = wbva_pkg::ADDR_W'(row) * wbva_pkg::ADDR_W'(wbva_pkg::MAX_POLS)
              + wbva_pkg::ADDR_W'(req_ch.pol_index);
      cmd.model_re = req_ch.model_re;
      cmd.model_im = req_ch.model_im;
      cmd.meas_re  = req_ch.meas_re;
      cmd.meas_im  = req_ch.meas_im;
      cmd.noise_re = req_ch.noise_re;
      case (req_ch.operation)
         wbva_pkg::OP_CLEAR: cmd.kind = wbva_pkg::K_CLEAR;
         wbva_pkg::OP_ACC: begin
            if (req_ch.beam_a != req_ch.beam_b || req_ch.antenna_a == req_ch.antenna_b)
               cmd.kind = wbva_pkg::K_TYPE;
            else if (!loc)
               cmd.kind = wbva_pkg::K_NOMATCH;
            else if (!pol_ok || req_ch.sample_flagged)
               cmd.kind = wbva_pkg::K_FLAG;
            else
               cmd.kind = wbva_pkg::K_ACC;
         end
         default: cmd.kind = (loc && pol_ok) ? wbva_pkg::K_RDHIT : wbva_pkg::K_RDMISS;
      endcase
   end

   assign req_ch.ready = !q_full && !hold_off;
   assign push = req_ch.valid && req_ch.ready;
endmodule
`default_nettype wire

// File: rtl/wbva_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on wbva_pkg.
`default_nettype none
module wbva_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wbva_pkg::cmd_type cmd_in,
   input  logic              pop,
   output wbva_pkg::cmd_type cmd_out,
   output logic              not_empty,
   output logic              full
);
   wbva_pkg::cmd_type slot_ff [2];
   logic [1:0] count_ff;
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) slot_ff[wr_ptr_ff] <= cmd_in;
   end

   assign cmd_out   = slot_ff[rd_ptr_ff];
   assign not_empty = count_ff != 2'd0;
   assign full      = count_ff == 2'd2;
endmodule
`default_nettype wire

// File: rtl/wbva_back.sv
// Back end: entry memory, weight divider and amplitude root unit, saturating sums.
// Depends on wbva_pkg and wbva_rsp_if.
`default_nettype none
module wbva_back (
   input  logic              clock,
   input  logic              reset,
   input  wbva_pkg::cmd_type head,
   input  logic              head_valid,
   output logic              pop,
   output logic              init_busy,
   wbva_rsp_if.source        rsp_ch
);
   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_CLEAR, S_READ, S_RDOUT, S_PREP, S_CALC, S_MUL, S_ADD, S_OUT
   } state_type;

   typedef struct packed {
      logic               flag;
      logic signed [47:0] amp;
      logic signed [47:0] pre;
      logic signed [47:0] pim;
   } entry_type;

   localparam entry_type EMPTY = '{flag: 1'b1, amp: '0, pre: '0, pim: '0};

   function automatic logic [31:0] cnt_inc(input logic [31:0] c);
      return (c == '1) ? c : c + 32'd1;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [48:0] s);
      if (s[48] != s[47]) return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      return s[47:0];
   endfunction

   state_type                  state_ff;
   wbva_pkg::cmd_type          cmd_ff;
   logic [wbva_pkg::ADDR_W-1:0] sweep_ff;
   logic [3:0]                 step_ff;
   logic [31:0]                type_cnt_ff, nomatch_cnt_ff, flag_cnt_ff;
   logic [30:0]                n2_ff, div_rem_ff;
   logic [31:0]                m2_ff;
   logic [15:0]                q_ff, root_ff;
   logic [19:0]                sq_rem_ff;
   logic signed [32:0]         cr_ff, ci_ff;
   logic [31:0]                wa_ff;
   logic signed [34:0]         wr_ff, wi_ff;
   logic [2:0]                 res_status_ff;
   logic [46:0]                res_amp_ff;
   logic signed [47:0]         res_pre_ff, res_pim_ff;
   logic                       res_flag_ff;
   entry_type                  mem_ram [wbva_pkg::DEPTH];
   entry_type                  rdata_ff;

   logic                       mem_we;
   logic [wbva_pkg::ADDR_W-1:0] mem_waddr;
   entry_type                  mem_wdata;
   entry_type                  upd;
   logic [30:0]                div_t;
   logic [19:0]                sq_t, sq_trial;
   logic [15:0]                weight;
   logic signed [17:0]         pr, pi;

   always_comb begin
      div_t    = {div_rem_ff[29:0], 1'b0};
      sq_t     = {sq_rem_ff[17:0], m2_ff[{~step_ff, 1'b0} +: 2]};
      sq_trial = {2'b00, root_ff, 2'b01};
      if (n2_ff == 31'd0)
         weight = 16'd0;
      else if (n2_ff <= 31'd16384)
         weight = 16'hFFFF;
      else
         weight = q_ff;
      pr = 18'(cr_ff >>> 15);
      pi = 18'(ci_ff >>> 15);
      upd.flag = 1'b0;
      upd.amp  = sat48($signed({rdata_ff.amp[47], rdata_ff.amp}) + $signed({17'd0, wa_ff}));
      upd.pre  = sat48($signed({rdata_ff.pre[47], rdata_ff.pre}) + 49'(wr_ff));
      upd.pim  = sat48($signed({rdata_ff.pim[47], rdata_ff.pim}) + 49'(wi_ff));
      mem_we    = (state_ff == S_INIT) || (state_ff == S_CLEAR) || (state_ff == S_ADD);
      mem_waddr = (state_ff == S_ADD) ? cmd_ff.idx : sweep_ff;
      mem_wdata = (state_ff == S_ADD) ? upd : EMPTY;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem_ram[mem_waddr] <= mem_wdata;
      rdata_ff <= mem_ram[cmd_ff.idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_INIT;
         sweep_ff       <= '0;
         step_ff        <= '0;
         type_cnt_ff    <= '0;
         nomatch_cnt_ff <= '0;
         flag_cnt_ff    <= '0;
      end else begin
         case (state_ff)
            S_INIT: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == wbva_pkg::ADDR_W'(wbva_pkg::DEPTH - 1)) begin
                  sweep_ff <= '0;
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (head_valid) begin
                  cmd_ff      <= head;
                  res_amp_ff  <= '0;
                  res_pre_ff  <= '0;
                  res_pim_ff  <= '0;
                  res_flag_ff <= 1'b0;
                  case (head.kind)
                     wbva_pkg::K_TYPE: begin
                        type_cnt_ff   <= cnt_inc(type_cnt_ff);
                        res_status_ff <= wbva_pkg::ST_TYPE;
                        state_ff      <= S_OUT;
                     end
                     wbva_pkg::K_NOMATCH: begin
                        nomatch_cnt_ff <= cnt_inc(nomatch_cnt_ff);
                        res_status_ff  <= wbva_pkg::ST_NOMATCH;
                        state_ff       <= S_OUT;
                     end
                     wbva_pkg::K_FLAG: begin
                        flag_cnt_ff   <= cnt_inc(flag_cnt_ff);
                        res_status_ff <= wbva_pkg::ST_FLAG;
                        state_ff      <= S_OUT;
                     end
                     wbva_pkg::K_RDMISS: begin
                        res_status_ff <= wbva_pkg::ST_READ;
                        res_flag_ff   <= 1'b1;
                        state_ff      <= S_OUT;
                     end
                     wbva_pkg::K_RDHIT: state_ff <= S_READ;
                     wbva_pkg::K_CLEAR: begin
                        type_cnt_ff    <= '0;
                        nomatch_cnt_ff <= '0;
                        flag_cnt_ff    <= '0;
                        res_status_ff  <= wbva_pkg::ST_CLEAR;
                        res_flag_ff    <= 1'b1;
                        state_ff       <= S_CLEAR;
                     end
                     default: state_ff <= S_PREP;
                  endcase
               end
            end
            S_CLEAR: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == wbva_pkg::ADDR_W'(wbva_pkg::DEPTH - 1)) begin
                  sweep_ff <= '0;
                  state_ff <= S_OUT;
               end
            end
            S_READ: state_ff <= S_RDOUT;
            S_RDOUT: begin
               res_status_ff <= wbva_pkg::ST_READ;
               res_amp_ff    <= rdata_ff.amp[46:0];
               res_pre_ff    <= rdata_ff.pre;
               res_pim_ff    <= rdata_ff.pim;
               res_flag_ff   <= rdata_ff.flag;
               state_ff      <= S_OUT;
            end
            S_PREP: begin
               n2_ff      <= 31'(cmd_ff.noise_re * cmd_ff.noise_re);
               m2_ff      <= 32'(cmd_ff.model_re * cmd_ff.model_re)
                           + 32'(cmd_ff.model_im * cmd_ff.model_im);
               cr_ff      <= 33'(cmd_ff.model_re * cmd_ff.meas_re)
                           + 33'(cmd_ff.model_im * cmd_ff.meas_im);
               ci_ff      <= 33'(cmd_ff.model_re * cmd_ff.meas_im)
                           - 33'(cmd_ff.model_im * cmd_ff.meas_re);
               div_rem_ff <= 31'd16384;
               q_ff       <= '0;
               sq_rem_ff  <= '0;
               root_ff    <= '0;
               step_ff    <= '0;
               state_ff   <= S_CALC;
            end
            S_CALC: begin
               if (div_t >= n2_ff) begin
                  div_rem_ff <= div_t - n2_ff;
                  q_ff       <= {q_ff[14:0], 1'b1};
               end else begin
                  div_rem_ff <= div_t;
                  q_ff       <= {q_ff[14:0], 1'b0};
               end
               if (sq_t >= sq_trial) begin
                  sq_rem_ff <= sq_t - sq_trial;
                  root_ff   <= {root_ff[14:0], 1'b1};
               end else begin
                  sq_rem_ff <= sq_t;
                  root_ff   <= {root_ff[14:0], 1'b0};
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == 4'd15) state_ff <= S_MUL;
            end
            S_MUL: begin
               wa_ff    <= weight * root_ff;
               wr_ff    <= $signed({1'b0, weight}) * pr;
               wi_ff    <= $signed({1'b0, weight}) * pi;
               state_ff <= S_ADD;
            end
            S_ADD: begin
               res_status_ff <= wbva_pkg::ST_ACC;
               res_amp_ff    <= upd.amp[46:0];
               res_pre_ff    <= upd.pre;
               res_pim_ff    <= upd.pim;
               res_flag_ff   <= 1'b0;
               state_ff      <= S_OUT;
            end
            S_OUT: if (rsp_ch.ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign pop       = (state_ff == S_IDLE) && head_valid;
   assign init_busy = state_ff == S_INIT;

   assign rsp_ch.valid              = state_ff == S_OUT;
   assign rsp_ch.status             = res_status_ff;
   assign rsp_ch.amp_sum            = res_amp_ff;
   assign rsp_ch.product_sum_re     = res_pre_ff;
   assign rsp_ch.product_sum_im     = res_pim_ff;
   assign rsp_ch.entry_flagged      = res_flag_ff;
   assign rsp_ch.type_ignored_count = type_cnt_ff;
   assign rsp_ch.no_match_count     = nomatch_cnt_ff;
   assign rsp_ch.flag_ignored_count = flag_cnt_ff;
endmodule
`default_nettype wire

// File: rtl/weighted_baseline_visibility_accumulator.sv
// Weighted baseline visibility accumulator: one result item per request item.
// Accumulates pass through a 16-step weight divider and amplitude root unit, then a multiply
// and a saturating add; clears sweep the whole entry memory before their result item.
// The back end works one item at a time; the queue holds two more.
// After reset a sweep empties the entry memory; no item is accepted until it ends.
// Depends on wbva_pkg, wbva_ifs, wbva_front, wbva_queue and wbva_back.
`default_nettype none
module weighted_baseline_visibility_accumulator (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [4:0] csr_wdata,
   wbva_req_if.sink   req_ch,
   wbva_rsp_if.source rsp_ch
);
   wbva_pkg::cmd_type push_cmd;
   wbva_pkg::cmd_type head_cmd;
   logic              push;
   logic              pop;
   logic              head_valid;
   logic              q_full;
   logic              init_busy;

   wbva_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .hold_off  (init_busy),
      .q_full    (q_full),
      .push      (push),
      .cmd       (push_cmd)
   );

   wbva_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .cmd_in    (push_cmd),
      .pop       (pop),
      .cmd_out   (head_cmd),
      .not_empty (head_valid),
      .full      (q_full)
   );

   wbva_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_cmd),
      .head_valid (head_valid),
      .pop        (pop),
      .init_busy  (init_busy),
      .rsp_ch     (rsp_ch)
   );
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking bench for the weighted baseline visibility accumulator.
// Drives request items from a queue, predicts each response item and checks it.
// Depends on wbva_pkg, wbva_ifs and the accumulator top level.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF;
   localparam longint SUM_MIN = -SUM_MAX - 1;

   typedef struct {
      logic [1:0]         op;
      logic [3:0]         ant_a;
      logic [3:0]         ant_b;
      logic [1:0]         beam_a;
      logic [1:0]         beam_b;
      logic [1:0]         pol;
      logic               flagged;
      logic signed [15:0] model_re;
      logic signed [15:0] model_im;
      logic signed [15:0] meas_re;
      logic signed [15:0] meas_im;
      logic signed [15:0] noise_re;
   } sample_type;

   typedef struct {
      logic [2:0]         status;
      logic [46:0]        amp;
      logic signed [47:0] prod_re;
      logic signed [47:0] prod_im;
      logic               flagged;
      logic [31:0]        type_cnt;
      logic [31:0]        nomatch_cnt;
      logic [31:0]        flag_cnt;
   } result_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [1:0] csr_index;
   logic [4:0] csr_wdata;

   wbva_req_if req();
   wbva_rsp_if rsp();

   weighted_baseline_visibility_accumulator uut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_ch(req.sink), .rsp_ch(rsp.source)
   );

   // predictor state
   logic signed [47:0] amp_acc [wbva_pkg::DEPTH];
   logic signed [47:0] re_acc [wbva_pkg::DEPTH];
   logic signed [47:0] im_acc [wbva_pkg::DEPTH];
   bit                 empty_entry [wbva_pkg::DEPTH];
   logic [31:0]        type_total, nomatch_total, flag_total;
   int                 cfg_ant, cfg_beams, cfg_pols;

   sample_type send_queue[$];
   result_type pending_results[$];
   int         mismatches = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   sample_type in_flight;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic int clamp(input int v, input int hi);
      return v > hi ? hi : v;
   endfunction

   function automatic logic [31:0] bump(input logic [31:0] c);
      return c == 32'hFFFF_FFFF ? c : c + 32'd1;
   endfunction

   function automatic logic signed [47:0] sat_sum(input longint s);
      if (s > SUM_MAX) return SUM_MAX[47:0];
      if (s < SUM_MIN) return SUM_MIN[47:0];
      return s[47:0];
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 32;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      return r;
   endfunction

   function automatic bit find_entry(input sample_type s, output int idx);
      int na, nb;
      na = clamp(cfg_ant, wbva_pkg::MAX_ANTENNAS);
      nb = clamp(cfg_beams, wbva_pkg::MAX_BEAMS);
      idx = 0;
      if (s.ant_a <= s.ant_b || s.ant_a >= na || s.beam_a >= nb) return 1'b0;
      idx = (s.beam_a * (na * (na - 1) / 2) + s.ant_a * (s.ant_a - 1) / 2 + s.ant_b)
            * wbva_pkg::MAX_POLS + s.pol;
      return idx < wbva_pkg::DEPTH;
   endfunction

   task automatic clear_entries();
      for (int i = 0; i < wbva_pkg::DEPTH; i++) begin
         amp_acc[i] = '0;
         re_acc[i] = '0;
         im_acc[i] = '0;
         empty_entry[i] = 1'b1;
      end
      type_total = '0;
      nomatch_total = '0;
      flag_total = '0;
   endtask

   task automatic fold_sample(input sample_type s);
      result_type r;
      int idx;
      bit hit, show;
      longint mr, mi, vr, vi, nr, w, amp, pr, pi;
      longint unsigned n2, q;
      hit = find_entry(s, idx);
      show = 1'b0;
      r.flagged = 1'b0;
      if (s.op == wbva_pkg::OP_CLEAR) begin
         clear_entries();
         r.status = wbva_pkg::ST_CLEAR;
         r.flagged = 1'b1;
      end else if (s.op != wbva_pkg::OP_ACC) begin
         r.status = wbva_pkg::ST_READ;
         r.flagged = 1'b1;
         show = hit && s.pol < clamp(cfg_pols, wbva_pkg::MAX_POLS);
      end else if (s.beam_a != s.beam_b || s.ant_a == s.ant_b) begin
         type_total = bump(type_total);
         r.status = wbva_pkg::ST_TYPE;
      end else if (!hit) begin
         nomatch_total = bump(nomatch_total);
         r.status = wbva_pkg::ST_NOMATCH;
      end else if (s.pol >= clamp(cfg_pols, wbva_pkg::MAX_POLS) || s.flagged) begin
         flag_total = bump(flag_total);
         r.status = wbva_pkg::ST_FLAG;
      end else begin
         mr = s.model_re;
         mi = s.model_im;
         vr = s.meas_re;
         vi = s.meas_im;
         nr = s.noise_re;
         n2 = nr * nr;
         w = 0;
         if (n2 != 0) begin
            q = (64'd1 << 30) / n2;
            w = q > 65535 ? 65535 : q;
         end
         amp = root_floor(mr * mr + mi * mi);
         pr = (mr * vr + mi * vi) >>> 15;
         pi = (mr * vi - mi * vr) >>> 15;
         amp_acc[idx] = sat_sum(longint'(amp_acc[idx]) + w * amp);
         re_acc[idx] = sat_sum(longint'(re_acc[idx]) + w * pr);
         im_acc[idx] = sat_sum(longint'(im_acc[idx]) + w * pi);
         empty_entry[idx] = 1'b0;
         r.status = wbva_pkg::ST_ACC;
         show = 1'b1;
      end
      if (show) begin
         r.amp = amp_acc[idx][46:0];
         r.prod_re = re_acc[idx];
         r.prod_im = im_acc[idx];
         r.flagged = empty_entry[idx];
      end else begin
         r.amp = '0;
         r.prod_re = '0;
         r.prod_im = '0;
      end
      r.type_cnt = type_total;
      r.nomatch_cnt = nomatch_total;
      r.flag_cnt = flag_total;
      pending_results.push_back(r);
   endtask

   task automatic report(input string what, input longint unsigned got,
                         input longint unsigned want);
      $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // driver
   always @(posedge clock) begin
      bit go;
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) fold_sample(in_flight);
         if (!req.valid || req.ready) begin
            go = send_queue.size() > 0 && $urandom_range(99) >= send_idle_pct;
            if (go) begin
               in_flight = send_queue.pop_front();
               req.operation <= in_flight.op;
               req.antenna_a <= in_flight.ant_a;
               req.antenna_b <= in_flight.ant_b;
               req.beam_a <= in_flight.beam_a;
               req.beam_b <= in_flight.beam_b;
               req.pol_index <= in_flight.pol;
               req.sample_flagged <= in_flight.flagged;
               req.model_re <= in_flight.model_re;
               req.model_im <= in_flight.model_im;
               req.meas_re <= in_flight.meas_re;
               req.meas_im <= in_flight.meas_im;
               req.noise_re <= in_flight.noise_re;
            end
            req.valid <= go;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (pending_results.size() == 0) begin
               report("unexpected item, status", rsp.status, 0);
            end else begin
               e = pending_results.pop_front();
               if (rsp.status !== e.status) report("status", rsp.status, e.status);
               if (rsp.amp_sum !== e.amp) report("amp_sum", rsp.amp_sum, e.amp);
               if (rsp.product_sum_re !== e.prod_re)
                  report("product_sum_re", rsp.product_sum_re, e.prod_re);
               if (rsp.product_sum_im !== e.prod_im)
                  report("product_sum_im", rsp.product_sum_im, e.prod_im);
               if (rsp.entry_flagged !== e.flagged)
                  report("entry_flagged", rsp.entry_flagged, e.flagged);
               if (rsp.type_ignored_count !== e.type_cnt)
                  report("type_ignored_count", rsp.type_ignored_count, e.type_cnt);
               if (rsp.no_match_count !== e.nomatch_cnt)
                  report("no_match_count", rsp.no_match_count, e.nomatch_cnt);
               if (rsp.flag_ignored_count !== e.flag_cnt)
                  report("flag_ignored_count", rsp.flag_ignored_count, e.flag_cnt);
            end
         end
         rsp.ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   function automatic logic [15:0] pick_value();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(255));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic sample_type make_sample(input logic [1:0] op, input int a, input int b,
                                              input int beam, input int pol);
      sample_type s;
      s.op = op;
      s.ant_a = 4'(a);
      s.ant_b = 4'(b);
      s.beam_a = 2'(beam);
      s.beam_b = 2'(beam);
      s.pol = 2'(pol);
      s.flagged = 1'b0;
      s.model_re = pick_value();
      s.model_im = pick_value();
      s.meas_re = pick_value();
      s.meas_im = pick_value();
      s.noise_re = $urandom_range(3) == 0 ? pick_value() : 16'($urandom_range(1, 2000));
      if ($urandom_range(1)) s.noise_re = -s.noise_re;
      return s;
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      int r, a;
      r = $urandom_range(99);
      a = $urandom_range(1, clamp(cfg_ant, wbva_pkg::MAX_ANTENNAS) - 1);
      s = make_sample(wbva_pkg::OP_ACC, a, $urandom_range(0, a - 1),
                      $urandom_range(0, clamp(cfg_beams, wbva_pkg::MAX_BEAMS) - 1),
                      $urandom_range(0, clamp(cfg_pols, wbva_pkg::MAX_POLS) - 1));
      if (r >= 60 && r < 82) begin
         s.op = wbva_pkg::OP_READ;
         s.beam_b = 2'($urandom);
      end else if (r == 82) begin
         s.op = wbva_pkg::OP_CLEAR;
      end else if (r > 82) begin
         s.op = 2'($urandom);
         if (s.op == wbva_pkg::OP_CLEAR) s.op = wbva_pkg::OP_ACC;
         s.ant_a = 4'($urandom);
         s.ant_b = 4'($urandom);
         s.beam_a = 2'($urandom);
         s.beam_b = $urandom_range(3) == 0 ? 2'($urandom) : s.beam_a;
         s.pol = 2'($urandom);
         s.flagged = 1'($urandom);
      end
      return s;
   endfunction

   task automatic push_directed(input logic [1:0] op, input int a, input int b,
                                input int beam, input int pol, input logic [15:0] mr,
                                input logic [15:0] mi, input logic [15:0] vr,
                                input logic [15:0] vi, input logic [15:0] nr);
      sample_type s;
      s = make_sample(op, a, b, beam, pol);
      s.model_re = mr;
      s.model_im = mi;
      s.meas_re = vr;
      s.meas_im = vi;
      s.noise_re = nr;
      send_queue.push_back(s);
   endtask

   task automatic wait_idle();
      while (send_queue.size() > 0 || pending_results.size() > 0 || req.valid)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_config(input int na, input int nb, input int np);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= wbva_pkg::CSR_NUM_ANT;
      csr_wdata <= 5'(na);
      @(posedge clock);
      csr_index <= wbva_pkg::CSR_NUM_BEAMS;
      csr_wdata <= 5'(nb);
      @(posedge clock);
      csr_index <= wbva_pkg::CSR_NUM_POLS;
      csr_wdata <= 5'(np);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_ant = na;
      cfg_beams = nb;
      cfg_pols = np;
   endtask

   initial begin
      int cfg [6][3];
      cfg = '{'{16, 4, 4}, '{2, 1, 1}, '{7, 3, 2}, '{16, 1, 4}, '{3, 4, 1}, '{16, 4, 4}};
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = wbva_pkg::CSR_NUM_ANT;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.operation = wbva_pkg::OP_ACC;
      req.antenna_a = '0;
      req.antenna_b = '0;
      req.beam_a = '0;
      req.beam_b = '0;
      req.pol_index = '0;
      req.sample_flagged = 1'b0;
      req.model_re = '0;
      req.model_im = '0;
      req.meas_re = '0;
      req.meas_im = '0;
      req.noise_re = '0;
      rsp.ready = 1'b0;
      cfg_ant = 16;
      cfg_beams = 4;
      cfg_pols = 4;
      clear_entries();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      push_directed(wbva_pkg::OP_ACC, 1, 0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                    16'h0001);
      push_directed(wbva_pkg::OP_ACC, 15, 14, 3, 3, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF,
                    16'h8000);
      push_directed(wbva_pkg::OP_ACC, 1, 0, 0, 0, 16'h1234, 16'hF00D, 16'h0100, 16'hFF00,
                    16'h0000);
      push_directed(wbva_pkg::OP_ACC, 1, 0, 0, 0, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
                    16'hFFFF);
      push_directed(wbva_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0);
      push_directed(wbva_pkg::OP_READ, 15, 14, 3, 3, 0, 0, 0, 0, 0);
      send_queue[$].beam_b = 2'd1;
      push_directed(wbva_pkg::OP_ACC, 5, 2, 1, 0, 16'h4000, 0, 16'h4000, 0, 16'h0100);
      send_queue[$].beam_b = 2'd2;
      push_directed(wbva_pkg::OP_ACC, 6, 6, 0, 0, 16'h4000, 0, 16'h4000, 0, 16'h0100);
      push_directed(wbva_pkg::OP_ACC, 2, 9, 0, 1, 16'h4000, 0, 16'h4000, 0, 16'h0100);
      push_directed(wbva_pkg::OP_ACC, 9, 2, 2, 2, 16'h4000, 0, 16'h4000, 0, 16'h0100);
      send_queue[$].flagged = 1'b1;
      push_directed(OP_SPARE, 15, 14, 3, 3, 0, 0, 0, 0, 0);
      push_directed(wbva_pkg::OP_READ, 3, 7, 0, 0, 0, 0, 0, 0, 0);
      push_directed(wbva_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      push_directed(wbva_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0);
      wait_idle();

      foreach (cfg[p]) begin
         write_config(cfg[p][0], cfg[p][1], cfg[p][2]);
         send_idle_pct = (p % 4 == 1) ? 65 : (p % 4 == 3) ? 19 : 0;
         recv_stall_pct = (p % 4 == 2) ? 65 : (p % 4 == 3) ? 19 : 0;
         if (p == 1) begin
            push_directed(wbva_pkg::OP_ACC, 1, 0, 1, 0, 16'h4000, 0, 16'h4000, 0, 16'h0100);
            push_directed(wbva_pkg::OP_ACC, 1, 0, 0, 1, 16'h4000, 0, 16'h4000, 0, 16'h0100);
            push_directed(wbva_pkg::OP_ACC, 2, 1, 0, 0, 16'h4000, 0, 16'h4000, 0, 16'h0100);
            push_directed(wbva_pkg::OP_READ, 1, 0, 0, 1, 0, 0, 0, 0, 0);
         end
         repeat (60) send_queue.push_back(random_sample());
         // hold the sender until every response item is back
         while (send_queue.size() > 0 || pending_results.size() > 0 || req.valid)
            @(negedge clock);
         repeat (65) send_queue.push_back(random_sample());
         wait_idle();
      end

      repeat (30) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
rtl/wbva_pkg.sv
rtl/wbva_ifs.sv
rtl/wbva_front.sv
rtl/wbva_queue.sv
rtl/wbva_back.sv
rtl/weighted_baseline_visibility_accumulator.sv
tb/tb_top.sv
